// ===== rtl/mf3_pkg.sv =====
package mf3_pkg;

	// Sizes fixed by the pixel and register formats
	localparam int MF3_MAX_WIDTH = 2048;
	localparam int PIX_W = 8;
	localparam int CFG_W = 12;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int MIN_DIM = 3;

	// 3x3 window: entry count, center tap, middle row newest column
	localparam int WIN_N = 9;
	localparam int WIN_MID = 4;
	localparam int WIN_RIGHT_MID = 5;

	// Register map (index = paddr[2])
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] WIDTH_RST = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

	// Request codes
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		pix_t hi;
		pix_t mid;
		pix_t lo;
	} trio_t;

	// Per-item control carried down the pipeline
	typedef struct packed {
		logic emit;
		logic upd;
		logic flush;
		logic selwin;
		logic border;
		logic fend;
	} stage_t;

	// Line buffer access controls
	typedef struct packed {
		logic rd;
		logic mid_wr;
		logic up_wr;
	} lb_ctl_t;

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
		trio_t t;
		t.lo = min3(a, b, c);
		t.hi = max3(a, b, c);
		t.mid = med3(a, b, c);
		return t;
	endfunction

endpackage

// ===== rtl/mf3_in_if.sv =====
interface mf3_in_if import mf3_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	pix_t pixel_value;

	modport source(output valid, req_type, pixel_value, input ready);
	modport sink(input valid, req_type, pixel_value, output ready);
endinterface

// ===== rtl/mf3_out_if.sv =====
interface mf3_out_if import mf3_pkg::*; ();
	logic valid;
	logic ready;
	pix_t out_pixel;
	logic frame_end;

	modport source(output valid, out_pixel, frame_end, input ready);
	modport sink(input valid, out_pixel, frame_end, output ready);
endinterface

// ===== rtl/median_filter_3x3.sv =====
// Path: a result passes stages 1 to 3 and the output register after the beat that releases it;
// a pixel's result is released by the pixel one line plus one pixel later, or by a flush.
// Throughput: one item per cycle unless stalled; 4-stage pipeline, one line-store access each.
// Reset: arst_n clears control state, width 640, height 480; line stores are then
// swept to zero, and no item is accepted during the sweep.
module median_filter_3x3 import mf3_pkg::*; #(
	parameter int MAX_WIDTH = MF3_MAX_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	mf3_in_if.sink            in_ch,
	mf3_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_WIDTH + 2);

	logic [CFG_W-1:0] width_q, height_q;
	logic [PW-1:0] w_eff, wp1;
	logic [CFG_W-1:0] h_eff;
	logic [CW-1:0] col_q, col_n;
	logic [CFG_W-1:0] row_q, row_n;
	logic [PW-1:0] pend_q, pend_n;
	logic cfg_wr, reg_idx;
	logic en, acc, busy;
	logic is_flush, take_flush, full, col_wrap;
	logic [CW-1:0] rd_addr;
	lb_ctl_t lb_ctl;
	stage_t s0, s1_q, s2_q, s3_q;
	logic [CW-1:0] col_s1;
	pix_t rd_top_s1, rd_mid_s1, fval_s2, pval_s3, med;
	pix_t in_ch_pix_s1;
	win_t win_q;
	logic out_v_q, frame_end_q;
	pix_t out_pixel_q;

	// Register port
	assign pready = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_WIDTH: prdata = {{(DATA_W-CFG_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(DATA_W-CFG_W){1'b0}}, height_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			if (reg_idx == REG_WIDTH) begin
				width_q <= pwdata[CFG_W-1:0];
			end else begin
				height_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	// Clamp the frame size
	always_comb begin
		if (width_q < CFG_W'(MIN_DIM)) begin
			w_eff = PW'(MIN_DIM);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = PW'(MAX_WIDTH);
		end else begin
			w_eff = PW'(width_q);
		end
		h_eff = (height_q < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) : height_q;
	end

	assign wp1 = w_eff + PW'(1);

	// Global advance: the whole pipeline moves when the output register is free
	assign en = !out_v_q || out_ch.ready;
	assign in_ch.ready = en && !busy;
	assign acc = in_ch.valid && in_ch.ready;

	// Decode the input beat against the stream position
	always_comb begin
		is_flush = (in_ch.req_type == REQ_FLUSH);
		full = (pend_q == wp1);
		take_flush = is_flush && (col_q == '0) && (row_q == '0) && (pend_q != '0);
		col_wrap = ((PW'(col_q) + PW'(1)) == w_eff);
		s0 = '0;
		rd_addr = col_q;
		col_n = col_q;
		row_n = row_q;
		pend_n = pend_q;
		if (is_flush) begin
			// Tail of the previous frame: last row, or the end of the row above
			rd_addr = CW'(w_eff - pend_q);
			s0.emit = take_flush;
			s0.flush = take_flush;
			s0.selwin = full;
			s0.fend = (pend_q == PW'(1));
			if (take_flush) begin
				pend_n = pend_q - PW'(1);
			end
		end else begin
			// Output sits one line plus one pixel back; border on first/last row or column
			s0.upd = 1'b1;
			s0.emit = full;
			s0.border = (col_q == '0) || (col_q == CW'(1)) ||
				(row_q == '0) || (row_q == CFG_W'(1));
			s0.fend = (col_q == '0) && (row_q == CFG_W'(1));
			if (col_wrap) begin
				col_n = '0;
				row_n = ((13'(row_q) + 13'd1) == 13'(h_eff)) ? '0 : row_q + CFG_W'(1);
			end else begin
				col_n = col_q + CW'(1);
			end
			if (!full) begin
				pend_n = pend_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pend_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
			pend_q <= '0;
		end else if (acc) begin
			col_q <= col_n;
			row_q <= row_n;
			pend_q <= pend_n;
		end
	end

	// Line stores
	always_comb begin
		lb_ctl.rd = acc && (!is_flush || take_flush);
		lb_ctl.mid_wr = acc && !is_flush;
		lb_ctl.up_wr = en && s1_q.upd;
	end

	mf3_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(lb_ctl),
		.rd_addr(rd_addr),
		.mid_wr_data(in_ch.pixel_value),
		.up_wr_addr(col_s1),
		.up_wr_data(rd_mid_s1),
		.rd_top(rd_top_s1),
		.rd_mid(rd_mid_s1),
		.busy(busy)
	);

	// Stage 1: beat decoded, store data read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (en) begin
			s1_q <= acc ? s0 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1 <= col_q;
		end
	end

	// Stage 2: shift the window, pick the flush value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			s2_q <= '0;
		end else if (en) begin
			s2_q <= s1_q;
			if (s1_q.upd) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[2] <= rd_top_s1;
				win_q[5] <= rd_mid_s1;
				win_q[8] <= in_ch_pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			in_ch_pix_s1 <= in_ch.pixel_value;
		end
		if (en) begin
			fval_s2 <= s1_q.selwin ? win_q[WIN_RIGHT_MID] : rd_mid_s1;
		end
	end

	// Stage 3: column sort, pass-through value
	mf3_median u_median (
		.clk(clk),
		.en(en),
		.win(win_q),
		.med(med)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_q <= '0;
		end else if (en) begin
			s3_q <= s2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pval_s3 <= s2_q.flush ? fval_s2 : win_q[WIN_MID];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= s3_q.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pixel_q <= (s3_q.flush || s3_q.border) ? pval_s3 : med;
			frame_end_q <= s3_q.fend;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.out_pixel = out_pixel_q;
	assign out_ch.frame_end = frame_end_q;

endmodule

// ===== rtl/mf3_line_buf.sv =====
module mf3_line_buf import mf3_pkg::*; #(
	parameter int MAX_WIDTH = MF3_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lb_ctl_t       ctl,
	input  logic [AW-1:0] rd_addr,
	input  pix_t          mid_wr_data,
	input  logic [AW-1:0] up_wr_addr,
	input  pix_t          up_wr_data,
	output pix_t          rd_top,
	output pix_t          rd_mid,
	output logic          busy
);

	localparam int CLW = $clog2(MAX_WIDTH + 1);

	pix_t upper [MAX_WIDTH];
	pix_t middle [MAX_WIDTH];
	logic [CLW-1:0] clr_q;
	logic [AW-1:0] clr_idx;

	assign busy = (clr_q != CLW'(MAX_WIDTH));
	assign clr_idx = clr_q[AW-1:0];

	// Sweep both stores to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + CLW'(1);
		end
	end

	// Upper row store: written one stage after the read, with the old middle value
	always_ff @(posedge clk) begin
		if (busy) begin
			upper[clr_idx] <= '0;
		end else if (ctl.up_wr) begin
			upper[up_wr_addr] <= up_wr_data;
		end
		if (ctl.rd) begin
			rd_top <= upper[rd_addr];
		end
	end

	// Middle row store: read old value and write the new pixel at the same column
	always_ff @(posedge clk) begin
		if (busy) begin
			middle[clr_idx] <= '0;
		end else if (ctl.mid_wr) begin
			middle[rd_addr] <= mid_wr_data;
		end
		if (ctl.rd) begin
			rd_mid <= middle[rd_addr];
		end
	end

endmodule

// ===== rtl/mf3_median.sv =====
module mf3_median import mf3_pkg::*; (
	input  logic clk,
	input  logic en,
	input  win_t win,
	output pix_t med
);

	trio_t c0, c1, c2;
	trio_t c0_s3, c1_s3, c2_s3;

	// Sort each window column
	always_comb begin
		c0 = sort3(win[0], win[3], win[6]);
		c1 = sort3(win[1], win[4], win[7]);
		c2 = sort3(win[2], win[5], win[8]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c0_s3 <= c0;
			c1_s3 <= c1;
			c2_s3 <= c2;
		end
	end

	// Median of max-of-lows, median-of-mids, min-of-highs
	assign med = med3(max3(c0_s3.lo, c1_s3.lo, c2_s3.lo),
		med3(c0_s3.mid, c1_s3.mid, c2_s3.mid),
		min3(c0_s3.hi, c1_s3.hi, c2_s3.hi));

endmodule
